// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on a rising edge with an
// active-low reset that disables checking.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== design/yldc_pkg.sv =====
// ----------------------------------------------------------------------------
// yldc_pkg
// Types, constants and coefficient helper for the BT.709 luma square
// darkening pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package yldc_pkg;

    // default coefficient fraction bits (Q2.14)
    localparam int COEFF_FRAC_DEF = 14;

    // configuration register indexes
    localparam logic [0:0] REG_DEPTH  = 1'b0;
    localparam logic [0:0] REG_FORMAT = 1'b1;

    // sample white levels and masks
    localparam logic [16:0] WHITE_8  = 17'd255;
    localparam logic [16:0] WHITE_16 = 17'd65535;
    localparam logic [15:0] MASK_8   = 16'h00FF;
    localparam logic [15:0] MASK_16  = 16'hFFFF;

    // per-beat mode bits
    typedef struct packed {
        logic depth;    // 1: 16-bit samples
        logic fmt;      // 1: YUV, luma curve only
    } mode_t;

    // one pixel, first channel in the low bits
    typedef struct packed {
        logic [15:0] alpha;
        logic [15:0] c;
        logic [15:0] b;
        logic [15:0] a;
    } pix_t;

    // forward matrix result
    typedef struct packed {
        mode_t              mode;
        logic [16:0]        sq_op;  // luma to be squared
        logic signed [16:0] ch_u;   // U, or raw second channel in YUV mode
        logic signed [16:0] ch_v;   // V, or raw third channel in YUV mode
        logic [15:0]        alpha;
    } fwd_t;

    // curved luma with chroma
    typedef struct packed {
        mode_t              mode;
        logic [16:0]        lut;
        logic signed [16:0] ch_u;
        logic signed [16:0] ch_v;
        logic [15:0]        alpha;
    } crv_t;

    // millionths to signed fixed point, rounded half away from zero
    function automatic longint qc(input longint k_mil, input int fbits);
        longint q_one;
        q_one = longint'(1) << fbits;
        if (k_mil < 0) begin
            return -(((-k_mil) * q_one + 64'sd500000) / 64'sd1000000);
        end
        return (k_mil * q_one + 64'sd500000) / 64'sd1000000;
    endfunction

endpackage

`default_nettype wire

// ===== design/yldc_fwd.sv =====
// ----------------------------------------------------------------------------
// yldc_fwd
// Input masking and BT.709 RGB to YUV matrix: register, multiply, sum,
// round. In YUV mode the channels ride through unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module yldc_fwd #(
    parameter int FRAC_BITS = yldc_pkg::COEFF_FRAC_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire yldc_pkg::pix_t  in_pix,
    input  wire yldc_pkg::mode_t in_mode,
    output logic                out_valid,
    input  wire logic           out_ready,
    output yldc_pkg::fwd_t      out_fwd
);
    import yldc_pkg::*;

    localparam int NS = 4;
    localparam int CW = FRAC_BITS + 2;
    localparam int PW = CW + 17;
    localparam int SW = PW + 2;

    localparam logic signed [CW-1:0] C_YR = CW'(qc(212600, FRAC_BITS));
    localparam logic signed [CW-1:0] C_YG = CW'(qc(715200, FRAC_BITS));
    localparam logic signed [CW-1:0] C_YB = CW'(qc(72200, FRAC_BITS));
    localparam logic signed [CW-1:0] C_UR = CW'(qc(-114572, FRAC_BITS));
    localparam logic signed [CW-1:0] C_UG = CW'(qc(-385428, FRAC_BITS));
    localparam logic signed [CW-1:0] C_UB = CW'(qc(500000, FRAC_BITS));
    localparam logic signed [CW-1:0] C_VR = CW'(qc(500000, FRAC_BITS));
    localparam logic signed [CW-1:0] C_VG = CW'(qc(-454153, FRAC_BITS));
    localparam logic signed [CW-1:0] C_VB = CW'(qc(-45847, FRAC_BITS));
    localparam logic signed [SW-1:0] HALF = SW'(longint'(1) << (FRAC_BITS - 1));

    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;

    // stage 0: masked input
    mode_t       s0_mode_reg;
    pix_t        s0_pix_reg;
    // stage 1: products
    mode_t              s1_mode_reg;
    pix_t               s1_pix_reg;
    logic signed [PW-1:0] s1_prod_reg [9];
    logic signed [PW-1:0] s1_prod_next [9];
    // stage 2: sums
    mode_t              s2_mode_reg;
    pix_t               s2_pix_reg;
    logic signed [SW-1:0] s2_sum_reg [3];
    logic signed [SW-1:0] s2_sum_next [3];
    // stage 3: rounded result
    fwd_t        s3_reg;
    fwd_t        s3_next;

    logic [15:0]        mask;
    logic signed [16:0] ch_r;
    logic signed [16:0] ch_g;
    logic signed [16:0] ch_b;
    logic signed [SW-1:0] rnd [3];
    logic signed [17:0]   qv [3];

    // stall chain: a stage loads when it is empty or its successor moves
    always_comb begin
        en[NS-1] = !v_reg[NS-1] || out_ready;
        for (int i = NS - 2; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];
    assign out_fwd   = s3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NS; i++) begin
                if (en[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // stage 0: drop the high byte in 8-bit mode
    assign mask = in_mode.depth ? MASK_16 : MASK_8;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            s0_mode_reg      <= in_mode;
            s0_pix_reg.a     <= in_pix.a & mask;
            s0_pix_reg.b     <= in_pix.b & mask;
            s0_pix_reg.c     <= in_pix.c & mask;
            s0_pix_reg.alpha <= in_pix.alpha & mask;
        end
    end

    // stage 1: nine coefficient products
    assign ch_r = {1'b0, s0_pix_reg.a};
    assign ch_g = {1'b0, s0_pix_reg.b};
    assign ch_b = {1'b0, s0_pix_reg.c};

    always_comb begin
        s1_prod_next[0] = ch_r * C_YR;
        s1_prod_next[1] = ch_g * C_YG;
        s1_prod_next[2] = ch_b * C_YB;
        s1_prod_next[3] = ch_r * C_UR;
        s1_prod_next[4] = ch_g * C_UG;
        s1_prod_next[5] = ch_b * C_UB;
        s1_prod_next[6] = ch_r * C_VR;
        s1_prod_next[7] = ch_g * C_VG;
        s1_prod_next[8] = ch_b * C_VB;
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            s1_mode_reg <= s0_mode_reg;
            s1_pix_reg  <= s0_pix_reg;
            s1_prod_reg <= s1_prod_next;
        end
    end

    // stage 2: row sums
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            s2_sum_next[r] = SW'(s1_prod_reg[3*r]) + SW'(s1_prod_reg[3*r+1])
                           + SW'(s1_prod_reg[3*r+2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            s2_mode_reg <= s1_mode_reg;
            s2_pix_reg  <= s1_pix_reg;
            s2_sum_reg  <= s2_sum_next;
        end
    end

    // stage 3: round half away from zero, i.e. (s + half - neg) >>> F
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            rnd[r] = s2_sum_reg[r] + HALF - SW'(s2_sum_reg[r][SW-1]);
            qv[r]  = 18'(rnd[r] >>> FRAC_BITS);
        end
        s3_next.mode  = s2_mode_reg;
        s3_next.alpha = s2_pix_reg.alpha;
        if (s2_mode_reg.fmt) begin
            s3_next.sq_op = {1'b0, s2_pix_reg.a};
            s3_next.ch_u  = {1'b0, s2_pix_reg.b};
            s3_next.ch_v  = {1'b0, s2_pix_reg.c};
        end else begin
            s3_next.sq_op = qv[0][17] ? 17'd0 : qv[0][16:0];
            s3_next.ch_u  = qv[1][16:0];
            s3_next.ch_v  = qv[2][16:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            s3_reg <= s3_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/yldc_curve.sv =====
// ----------------------------------------------------------------------------
// yldc_curve
// Luma square curve floor(y*y/white): square, reciprocal estimate for a
// divisor of 2^k-1, then one remainder correction.
// ----------------------------------------------------------------------------
`default_nettype none

module yldc_curve (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire yldc_pkg::fwd_t in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output yldc_pkg::crv_t     out_crv
);
    import yldc_pkg::*;

    localparam int NS = 3;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;

    // stage 0: square
    fwd_t        s0_reg;
    logic [33:0] s0_sq_reg;
    // stage 1: quotient estimate
    fwd_t        s1_reg;
    logic [17:0] s1_x_reg;
    logic [17:0] s1_q0_reg;
    logic [17:0] s1_q0_next;
    logic [34:0] xs;
    // stage 2: corrected quotient
    crv_t        s2_reg;
    crv_t        s2_next;
    logic [17:0] qw;
    logic [17:0] rem;
    logic [16:0] white;
    logic        bump;

    always_comb begin
        en[NS-1] = !v_reg[NS-1] || out_ready;
        for (int i = NS - 2; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];
    assign out_crv   = s2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NS; i++) begin
                if (en[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // stage 0: luma squared
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            s0_reg    <= in_data;
            s0_sq_reg <= in_data.sq_op * in_data.sq_op;
        end
    end

    // stage 1: x/(2^k-1) ~ (x + x>>k) >> k, low by at most one
    always_comb begin
        if (s0_reg.mode.depth) begin
            xs         = {1'b0, s0_sq_reg} + 35'(s0_sq_reg >> 16);
            s1_q0_next = xs[33:16];
        end else begin
            xs         = {1'b0, s0_sq_reg} + 35'(s0_sq_reg >> 8);
            s1_q0_next = xs[25:8];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            s1_reg    <= s0_reg;
            s1_x_reg  <= s0_sq_reg[17:0];
            s1_q0_reg <= s1_q0_next;
        end
    end

    // stage 2: remainder below 2*white, taken mod 2^18
    always_comb begin
        if (s1_reg.mode.depth) begin
            qw    = {s1_q0_reg[1:0], 16'd0};
            white = WHITE_16;
        end else begin
            qw    = {s1_q0_reg[9:0], 8'd0};
            white = WHITE_8;
        end
        rem  = s1_x_reg - qw + s1_q0_reg;
        bump = rem >= {1'b0, white};
        s2_next.mode  = s1_reg.mode;
        s2_next.lut   = s1_q0_reg[16:0] + 17'(bump);
        s2_next.ch_u  = s1_reg.ch_u;
        s2_next.ch_v  = s1_reg.ch_v;
        s2_next.alpha = s1_reg.alpha;
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            s2_reg <= s2_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/yldc_inv.sv =====
// ----------------------------------------------------------------------------
// yldc_inv
// BT.709 YUV to RGB matrix on the curved luma: multiply, sum, then clamp
// to 0..white with truncation. YUV mode picks the curved luma and raw chroma.
// ----------------------------------------------------------------------------
`default_nettype none

module yldc_inv #(
    parameter int FRAC_BITS = yldc_pkg::COEFF_FRAC_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire yldc_pkg::crv_t in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output yldc_pkg::pix_t     out_pix
);
    import yldc_pkg::*;

    localparam int NS = 3;
    localparam int CW = FRAC_BITS + 2;
    localparam int PW = CW + 18;
    localparam int SW = PW + 2;
    localparam int TW = SW - FRAC_BITS;

    localparam logic signed [CW-1:0] C_RY = CW'(qc(1000000, FRAC_BITS));
    localparam logic signed [CW-1:0] C_RU = CW'(qc(0, FRAC_BITS));
    localparam logic signed [CW-1:0] C_RV = CW'(qc(1574800, FRAC_BITS));
    localparam logic signed [CW-1:0] C_GY = CW'(qc(1000000, FRAC_BITS));
    localparam logic signed [CW-1:0] C_GU = CW'(qc(-187324, FRAC_BITS));
    localparam logic signed [CW-1:0] C_GV = CW'(qc(-468124, FRAC_BITS));
    localparam logic signed [CW-1:0] C_BY = CW'(qc(1000000, FRAC_BITS));
    localparam logic signed [CW-1:0] C_BU = CW'(qc(1855600, FRAC_BITS));
    localparam logic signed [CW-1:0] C_BV = CW'(qc(0, FRAC_BITS));

    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;

    // stage 0: products
    crv_t                 s0_reg;
    logic signed [PW-1:0] s0_prod_reg [9];
    logic signed [PW-1:0] s0_prod_next [9];
    logic signed [17:0]   ch_y;
    // stage 1: sums
    crv_t                 s1_reg;
    logic signed [SW-1:0] s1_sum_reg [3];
    logic signed [SW-1:0] s1_sum_next [3];
    // stage 2: clamped pixel
    pix_t                 s2_reg;
    pix_t                 s2_next;
    logic [TW-1:0]        trunc [3];
    logic [15:0]          chan [3];
    logic [16:0]          white;

    always_comb begin
        en[NS-1] = !v_reg[NS-1] || out_ready;
        for (int i = NS - 2; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];
    assign out_pix   = s2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NS; i++) begin
                if (en[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // stage 0: coefficient products
    assign ch_y = {1'b0, in_data.lut};

    always_comb begin
        s0_prod_next[0] = ch_y * C_RY;
        s0_prod_next[1] = in_data.ch_u * C_RU;
        s0_prod_next[2] = in_data.ch_v * C_RV;
        s0_prod_next[3] = ch_y * C_GY;
        s0_prod_next[4] = in_data.ch_u * C_GU;
        s0_prod_next[5] = in_data.ch_v * C_GV;
        s0_prod_next[6] = ch_y * C_BY;
        s0_prod_next[7] = in_data.ch_u * C_BU;
        s0_prod_next[8] = in_data.ch_v * C_BV;
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            s0_reg      <= in_data;
            s0_prod_reg <= s0_prod_next;
        end
    end

    // stage 1: row sums
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            s1_sum_next[r] = SW'(s0_prod_reg[3*r]) + SW'(s0_prod_reg[3*r+1])
                           + SW'(s0_prod_reg[3*r+2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            s1_reg     <= s0_reg;
            s1_sum_reg <= s1_sum_next;
        end
    end

    // stage 2: negative to zero, truncate, saturate at white
    assign white = s1_reg.mode.depth ? WHITE_16 : WHITE_8;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            trunc[r] = s1_sum_reg[r][SW-1:FRAC_BITS];
            if (s1_sum_reg[r][SW-1]) begin
                chan[r] = 16'd0;
            end else if (trunc[r] > TW'(white)) begin
                chan[r] = white[15:0];
            end else begin
                chan[r] = trunc[r][15:0];
            end
        end
        s2_next.alpha = s1_reg.alpha;
        if (s1_reg.mode.fmt) begin
            s2_next.a = s1_reg.lut[15:0];
            s2_next.b = s1_reg.ch_u[15:0];
            s2_next.c = s1_reg.ch_v[15:0];
        end else begin
            s2_next.a = chan[0];
            s2_next.b = chan[1];
            s2_next.c = chan[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            s2_reg <= s2_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/yldc_skid.sv =====
// ----------------------------------------------------------------------------
// yldc_skid
// Output register with one skid entry, so the upstream ready comes from a
// flop rather than from the downstream ready.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module yldc_skid (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire yldc_pkg::pix_t in_pix,
    output logic               out_valid,
    input  wire logic          out_ready,
    output yldc_pkg::pix_t     out_pix
);
    import yldc_pkg::*;

    logic out_valid_reg;
    logic skid_valid_reg;
    pix_t out_pix_reg;
    pix_t skid_pix_reg;
    logic out_free;

    assign out_free  = out_ready || !out_valid_reg;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_pix   = out_pix_reg;

    // occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg  <= skid_valid_reg || in_valid;
            skid_valid_reg <= 1'b0;
        end else if (in_valid && !skid_valid_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_pix_reg <= skid_valid_reg ? skid_pix_reg : in_pix;
        end else if (in_valid && !skid_valid_reg) begin
            skid_pix_reg <= in_pix;
        end
    end

    `ASSERT_IMP(a_skid_needs_out, aclk, aresetn, skid_valid_reg, out_valid_reg, "skid full, output empty")
    `ASSERT_NXT(a_skid_holds, aclk, aresetn, skid_valid_reg && !out_ready, skid_valid_reg && out_valid_reg, "skid beat lost under stall")
    `ASSERT_IMP(a_skid_fill_stall, aclk, aresetn, $rose(skid_valid_reg), $past(out_valid_reg && !out_ready), "skid filled without stall")

endmodule

`default_nettype wire

// ===== design/yuv_luma_square_dark_curve.sv =====
// Pipeline: an accepted s_ beat passes 4 forward matrix, 3 luma curve and
//   3 inverse matrix stages and 1 output register on its way to m_tvalid.
// Throughput: one pixel per cycle; every stage of every unit takes a new beat
//   each cycle, and a stall holds the pipeline with a skid entry at the output.
// Reset: aresetn, synchronous active low, empties the pipeline and clears
//   depth_mode and format_mode to 0 (8-bit RGB).
// ----------------------------------------------------------------------------
// yuv_luma_square_dark_curve
// BT.709 luma square tone curve: darkens each pixel by replacing luma Y
// with Y*Y/white, in RGB through the color matrix or directly in YUV.
// ----------------------------------------------------------------------------
`default_nettype none

module yuv_luma_square_dark_curve #(
    parameter int COEFF_FRACTION_BITS = yldc_pkg::COEFF_FRAC_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [0:0]  cfg_data,
    // input pixels
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // chan_a, chan_b, chan_c, alpha_in
    // result pixels
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata    // out_a, out_b, out_c, alpha_out
);
    import yldc_pkg::*;

    logic  depth_mode_reg;
    logic  format_mode_reg;
    mode_t mode;
    pix_t  in_pix;
    pix_t  out_pix;
    pix_t  inv_pix;

    logic  fwd_valid;
    logic  fwd_ready;
    fwd_t  fwd_data;
    logic  crv_valid;
    logic  crv_ready;
    crv_t  crv_data;
    logic  inv_valid;
    logic  inv_ready;

    // configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_mode_reg  <= 1'b0;
            format_mode_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_DEPTH:  depth_mode_reg  <= cfg_data[0];
                REG_FORMAT: format_mode_reg <= cfg_data[0];
            endcase
        end
    end

    assign mode.depth = depth_mode_reg;
    assign mode.fmt   = format_mode_reg;
    assign in_pix     = pix_t'(s_tdata);
    assign m_tdata    = out_pix;

    yldc_fwd #(
        .FRAC_BITS (COEFF_FRACTION_BITS)
    ) u_fwd (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pix    (in_pix),
        .in_mode   (mode),
        .out_valid (fwd_valid),
        .out_ready (fwd_ready),
        .out_fwd   (fwd_data)
    );

    yldc_curve u_curve (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fwd_valid),
        .in_ready  (fwd_ready),
        .in_data   (fwd_data),
        .out_valid (crv_valid),
        .out_ready (crv_ready),
        .out_crv   (crv_data)
    );

    yldc_inv #(
        .FRAC_BITS (COEFF_FRACTION_BITS)
    ) u_inv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (crv_valid),
        .in_ready  (crv_ready),
        .in_data   (crv_data),
        .out_valid (inv_valid),
        .out_ready (inv_ready),
        .out_pix   (inv_pix)
    );

    yldc_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (inv_valid),
        .in_ready  (inv_ready),
        .in_pix    (inv_pix),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pix   (out_pix)
    );

endmodule

`default_nettype wire

// ===== bench/yuv_luma_square_dark_curve_tb.sv =====
// ----------------------------------------------------------------------------
// yuv_luma_square_dark_curve_tb
// Self-checking bench for the luma square darkening pipeline. A directed
// vector list covers black, white, the primaries, ignored high bytes and
// both formats at both depths. Random pixels follow, in phases at different
// register settings. Every result beat is checked field by field against a typed-in
// result or the fixed-point bench model. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module yuv_luma_square_dark_curve_tb;

    import yldc_pkg::*;

    localparam int     FRAC        = COEFF_FRAC_DEF;
    localparam int     LAT_SLACK   = 16;        // pipeline depth plus skid, rounded up
    localparam int     SQUEEZE_LEN = 64;        // long output hold, deeper than the pipe
    localparam int     RAND_PHASES = 8;
    localparam int     PHASE_ITEMS = 192;
    localparam longint RUN_LIMIT   = 64'd7_000_000;

    // ------------------------------------------------------------------------
    // fixed-point color matrix
    // ------------------------------------------------------------------------
    // millionths to signed Q with FRAC fraction bits, half away from zero
    function automatic longint to_fixed(input longint mil);
        longint one;
        one = longint'(1) << FRAC;
        if (mil < 0) begin
            return -(((-mil) * one + 500000) / 1000000);
        end
        return (mil * one + 500000) / 1000000;
    endfunction

    // forward: Y, U, V rows from R, G, B
    localparam longint K_YR = to_fixed(212600);
    localparam longint K_YG = to_fixed(715200);
    localparam longint K_YB = to_fixed(72200);
    localparam longint K_UR = to_fixed(-114572);
    localparam longint K_UG = to_fixed(-385428);
    localparam longint K_UB = to_fixed(500000);
    localparam longint K_VR = to_fixed(500000);
    localparam longint K_VG = to_fixed(-454153);
    localparam longint K_VB = to_fixed(-45847);
    // inverse: R, G, B rows from Y, U, V
    localparam longint K_RY = to_fixed(1000000);
    localparam longint K_RU = to_fixed(0);
    localparam longint K_RV = to_fixed(1574800);
    localparam longint K_GY = to_fixed(1000000);
    localparam longint K_GU = to_fixed(-187324);
    localparam longint K_GV = to_fixed(-468124);
    localparam longint K_BY = to_fixed(1000000);
    localparam longint K_BU = to_fixed(1855600);
    localparam longint K_BV = to_fixed(0);

    // drop the fraction, rounding half away from zero
    function automatic longint fix_round(input longint acc);
        longint half;
        half = longint'(1) << (FRAC - 1);
        if (acc >= 0) begin
            return (acc + half) >>> FRAC;
        end
        return -(((-acc) + half) >>> FRAC);
    endfunction

    // inverse matrix sum to a sample: negative is black, truncate, clip at white
    function automatic logic [15:0] to_sample(input longint acc, input longint white);
        longint s;
        if (acc < 0) begin
            return 16'd0;
        end
        s = acc >>> FRAC;
        if (s > white) begin
            s = white;
        end
        return 16'(s);
    endfunction

    // expected output pixel {alpha, c, b, a} for one input pixel
    function automatic logic [63:0] darken_pixel(input logic [63:0] px, input bit deep,
                                                 input bit yuv);
        longint      white, ca, cb, cc, y, u, v, lut;
        logic [15:0] oa, ob, oc, oal;
        white = deep ? 64'd65535 : 64'd255;
        ca    = longint'(px[15:0]) & white;
        cb    = longint'(px[31:16]) & white;
        cc    = longint'(px[47:32]) & white;
        oal   = 16'(longint'(px[63:48]) & white);
        if (yuv) begin
            oa = 16'(ca * ca / white);
            ob = 16'(cb);
            oc = 16'(cc);
        end else begin
            y = fix_round(K_YR * ca + K_YG * cb + K_YB * cc);
            u = fix_round(K_UR * ca + K_UG * cb + K_UB * cc);
            v = fix_round(K_VR * ca + K_VG * cb + K_VB * cc);
            if (y < 0) begin
                y = 0;
            end
            lut = y * y / white;
            oa  = to_sample(K_RY * lut + K_RU * u + K_RV * v, white);
            ob  = to_sample(K_GY * lut + K_GU * u + K_GV * v, white);
            oc  = to_sample(K_BY * lut + K_BU * u + K_BV * v, white);
        end
        return {oal, oc, ob, oa};
    endfunction

    // ------------------------------------------------------------------------
    // DUT and signals
    // ------------------------------------------------------------------------
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = REG_DEPTH;
    logic [0:0]  cfg_data  = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;    // chan_a, chan_b, chan_c, alpha_in
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;           // out_a, out_b, out_c, alpha_out

    yuv_luma_square_dark_curve dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    logic [63:0] pending_px[$];     // predicted output pixels, oldest first
    bit          depth_q;           // bench copy of depth_mode
    bit          fmt_q;             // bench copy of format_mode
    bit          no_idle_tx;
    bit          no_idle_rx;
    bit          squeeze_req;
    int          mismatch_cnt;
    int          result_cnt;
    int          mode_switch_cnt;
    int          squeeze_cnt;
    int          mode_px_cnt[4];    // indexed {depth, format}

    // clock
    initial begin
        forever begin
            #5 aclk = ~aclk;
        end
    end

    // run limit
    initial begin
        #(RUN_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(12, 40);
    endfunction

    // one sample, leaning toward black and white of the current depth
    function automatic logic [15:0] pick_sample(input bit deep);
        logic [15:0] val, w;
        int          r;
        w   = deep ? MASK_16 : MASK_8;
        val = 16'($urandom);
        r   = $urandom_range(0, 9);
        if (r == 0) begin
            val = val & ~w;
        end else if (r == 1) begin
            val = val | w;
        end
        return val;
    endfunction

    function automatic logic [63:0] pick_pixel(input bit deep);
        logic [15:0] ca, cb, cc, al;
        ca = pick_sample(deep);
        cb = pick_sample(deep);
        cc = pick_sample(deep);
        al = 16'($urandom);
        // gray pixels: zero chroma in RGB mode
        if ($urandom_range(0, 9) == 0) begin
            cb = ca;
            cc = ca;
        end
        return {al, cc, cb, ca};
    endfunction

    // one pixel beat; the prediction is queued at the accepting edge
    task automatic send_pixel(input logic [63:0] px, input logic [63:0] want, input int gap);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        pending_px.push_back(want);
        mode_px_cnt[{depth_q, fmt_q}]++;
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic cfg_write(input logic [0:0] idx, input logic [0:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        case (idx)
            REG_DEPTH:  depth_q = val;
            REG_FORMAT: fmt_q   = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // stop sending and let every queued pixel come out
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_px.size() != 0) begin
            @(posedge aclk);
        end
        repeat (LAT_SLACK) @(posedge aclk);
    endtask

    task automatic set_mode(input bit deep, input bit yuv);
        wait_idle();
        cfg_write(REG_DEPTH, deep);
        cfg_write(REG_FORMAT, yuv);
        mode_switch_cnt++;
    endtask

    // ------------------------------------------------------------------------
    // directed vectors; pixels are written {alpha, c, b, a}
    // ------------------------------------------------------------------------
    typedef struct packed {
        bit          deep;
        bit          yuv;
        logic [63:0] px;
        bit          known;     // res holds the typed-in result
        logic [63:0] res;
    } dir_row_t;

    localparam int DIR_N = 21;
    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        // 8-bit RGB, the reset setting
        '{1'b0, 1'b0, 64'h0000_0000_0000_0000, 1'b1, 64'h0000_0000_0000_0000},
        '{1'b0, 1'b0, 64'h00FF_00FF_00FF_00FF, 1'b1, 64'h00FF_00FF_00FF_00FF},
        '{1'b0, 1'b0, 64'h0080_0000_0000_00FF, 1'b0, 64'h0},
        '{1'b0, 1'b0, 64'h0000_0000_00FF_0000, 1'b0, 64'h0},
        '{1'b0, 1'b0, 64'h0000_00FF_0000_0000, 1'b0, 64'h0},
        '{1'b0, 1'b0, 64'hFF00_FFFF_FF00_00FF, 1'b0, 64'h0},   // high bytes dropped
        '{1'b0, 1'b0, 64'h1234_5678_9ABC_DEF0, 1'b0, 64'h0},
        // 8-bit YUV
        '{1'b0, 1'b1, 64'h0000_0000_0000_0000, 1'b1, 64'h0000_0000_0000_0000},
        '{1'b0, 1'b1, 64'h00FF_00FF_00FF_00FF, 1'b1, 64'h00FF_00FF_00FF_00FF},
        '{1'b0, 1'b1, 64'hFFFF_FF00_1234_FF80, 1'b0, 64'h0},   // high bytes dropped
        '{1'b0, 1'b1, 64'h0011_0022_0033_0080, 1'b0, 64'h0},
        // 16-bit YUV
        '{1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
        '{1'b1, 1'b1, 64'h0000_FFFF_0000_0000, 1'b1, 64'h0000_FFFF_0000_0000},
        '{1'b1, 1'b1, 64'h1234_8000_0001_8000, 1'b0, 64'h0},
        // 16-bit RGB
        '{1'b1, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
        '{1'b1, 1'b0, 64'h0000_0000_0000_0000, 1'b1, 64'h0000_0000_0000_0000},
        '{1'b1, 1'b0, 64'h0000_0000_0000_FFFF, 1'b0, 64'h0},
        '{1'b1, 1'b0, 64'h0000_0000_FFFF_0000, 1'b0, 64'h0},
        '{1'b1, 1'b0, 64'h5A5A_FFFF_0000_0000, 1'b0, 64'h0},
        '{1'b1, 1'b0, 64'h8000_0001_7FFF_C000, 1'b0, 64'h0},
        // back to the reset setting
        '{1'b0, 1'b0, 64'h00FF_0001_0001_0001, 1'b0, 64'h0}
    };

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        dir_row_t    row;
        logic [63:0] px;
        int          mode_sel;
        bit          deep, yuv;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed vectors
        for (int i = 0; i < DIR_N; i++) begin
            row = DIR_ROWS[i];
            if (row.deep != depth_q || row.yuv != fmt_q) begin
                set_mode(row.deep, row.yuv);
            end
            send_pixel(row.px, row.known ? row.res : darken_pixel(row.px, row.deep, row.yuv),
                       pick_gap());
        end

        // random phases: all four settings first, then random ones
        for (int p = 0; p < RAND_PHASES; p++) begin
            mode_sel = (p < 4) ? (3 - p) : $urandom_range(0, 3);
            deep     = mode_sel[1];
            yuv      = mode_sel[0];
            set_mode(deep, yuv);
            no_idle_tx = (p % 4 == 1) || (p % 4 == 3);
            no_idle_rx = (p % 4 == 3);
            // back-pressure burst: output held while input keeps coming
            if (p % 4 == 1) begin
                squeeze_req = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                px = pick_pixel(deep);
                send_pixel(px, darken_pixel(px, deep, yuv), no_idle_tx ? 0 : pick_gap());
            end
        end
        no_idle_tx = 1'b0;
        no_idle_rx = 1'b0;

        wait_idle();
        $display("Sent %0d pixels: 8-bit RGB %0d, 8-bit YUV %0d, 16-bit RGB %0d, 16-bit YUV %0d",
                 mode_px_cnt[0] + mode_px_cnt[1] + mode_px_cnt[2] + mode_px_cnt[3],
                 mode_px_cnt[0], mode_px_cnt[1], mode_px_cnt[2], mode_px_cnt[3]);
        $display("Checked %0d results over %0d setting changes, %0d long output stalls",
                 result_cnt, mode_switch_cnt, squeeze_cnt);
        if (mismatch_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // output ready: random holds, plus the long squeeze on request
    // ------------------------------------------------------------------------
    initial begin
        int hold;
        int r;
        hold = 0;
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if (squeeze_req) begin
                squeeze_req = 1'b0;
                squeeze_cnt++;
                hold = SQUEEZE_LEN - 1;
                m_tready <= 1'b0;
            end else if (no_idle_rx) begin
                m_tready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    m_tready <= 1'b1;
                end else begin
                    hold = (r < 95) ? $urandom_range(0, 2) : $urandom_range(11, 39);
                    m_tready <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, want, got);
        mismatch_cnt++;
    endtask

    string field_name[4] = '{"out_a", "out_b", "out_c", "alpha_out"};

    always @(posedge aclk) begin
        logic [63:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_px.size() == 0) begin
                report_mismatch("unexpected result beat", 64'h0, m_tdata);
            end else begin
                want = pending_px.pop_front();
                result_cnt++;
                for (int k = 0; k < 4; k++) begin
                    if (m_tdata[k*16 +: 16] !== want[k*16 +: 16]) begin
                        report_mismatch(field_name[k], 64'(want[k*16 +: 16]),
                                        64'(m_tdata[k*16 +: 16]));
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire
